// ===== src/bole_pkg.sv =====
// Shared constants and codes for the bounded ordered list engine.
package bole_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 3;
  localparam int POS_IN_W = 5;
  localparam int POS_W    = 6;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_END   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_VAL   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

endpackage

// ===== src/bole_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: sequencer, list RAM and result port.
//
// The engine holds an ordered list of up to 32 signed 32-bit values in a
// circular buffer inside one RAM, and serves one request at a time: a request
// beat is taken when start is high and busy is low. Every result beat is shown
// on the result ports for exactly one cycle with result_valid high, and the
// receiver cannot stall it. Inserts answer in the next cycle, and busy
// stays low. Search scans the list up to the match, delete by value scans to
// the match and then shifts the later entries down, delete by position
// shifts the entries past pos down, and dump gives one result beat per cycle.
// The walk is paced by the single RAM read port: one entry is read per cycle
// and its registered read data is then compared, moved or emitted.
// Error cases (full, empty, bad position) answer in the cycle after the beat.
// Request codes 6 and 7 are taken and ignored; they give no result beat.
module bounded_ordered_list_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bole_pkg::REQ_W-1:0]            req_type,
  input  logic signed [bole_pkg::DATA_W-1:0]    item_value,
  input  logic [bole_pkg::POS_IN_W-1:0]         item_position,
  output logic                                  result_valid,
  output logic [bole_pkg::STAT_W-1:0]           status,
  output logic signed [bole_pkg::DATA_W-1:0]    result_value,
  output logic [bole_pkg::POS_W-1:0]            result_position,
  output logic [bole_pkg::POS_W-1:0]            list_length,
  output logic                                  last_of_run
);

  localparam int ADDR_W = bole_pkg::ADDR_W;
  localparam int CNT_W  = bole_pkg::CNT_W;
  localparam int SUM_W  = bole_pkg::SUM_W;
  localparam int DATA_W = bole_pkg::DATA_W;
  localparam int POS_W  = bole_pkg::POS_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_TAKE  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DUMP  = 3'd5;

  logic [2:0]              state;
  logic [ADDR_W-1:0]       head;      // physical address of list position 0
  logic [CNT_W-1:0]        count;     // number of valid entries
  logic                    del_mode;  // scan deletes the match instead of reporting it
  logic [DATA_W-1:0]       val_reg;
  logic [CNT_W-1:0]        rd_idx;    // logical index of the next read
  logic                    cmp_valid; // rd_data holds entry cmp_idx
  logic [CNT_W-1:0]        cmp_idx;
  logic                    wr_pend;   // rd_data is to be written back at wr_addr
  logic [ADDR_W-1:0]       wr_addr;
  logic [DATA_W-1:0]       rm_value;

  // RAM port
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [DATA_W-1:0]       rd_data;

  // Shared address unit: logical index to physical address, with wrap
  logic [CNT_W-1:0]        addr_idx;
  logic [SUM_W-1:0]        addr_raw;
  logic [ADDR_W-1:0]       addr_sum;
  logic [ADDR_W-1:0]       head_dec;
  logic [ADDR_W-1:0]       sum_dec;

  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  logic                    walk_state;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count == CNT_W'(bole_pkg::CAPACITY));
  assign is_empty = (count == '0);

  assign addr_idx = (state == S_IDLE) ? count : rd_idx;
  assign addr_raw = SUM_W'(head) + SUM_W'(addr_idx);

  always_comb begin
    if (addr_raw >= SUM_W'(bole_pkg::CAPACITY)) begin
      addr_sum = ADDR_W'(addr_raw - SUM_W'(bole_pkg::CAPACITY));
    end else begin
      addr_sum = ADDR_W'(addr_raw);
    end
  end

  assign head_dec = (head == '0) ? ADDR_W'(bole_pkg::CAPACITY - 1) : head - ADDR_W'(1);
  assign sum_dec  = (addr_sum == '0) ? ADDR_W'(bole_pkg::CAPACITY - 1)
                                     : addr_sum - ADDR_W'(1);

  assign walk_state = (state == S_SCAN) || (state == S_DUMP) || (state == S_SHIFT);

  // Drive the RAM: inserts write at accept, the shift walk writes back one behind
  always_comb begin
    ram_re = (state == S_FETCH) || (walk_state && (rd_idx < count));
    if (state == S_IDLE) begin
      ram_we    = accept && !is_full &&
                  ((req_type == bole_pkg::REQ_INS_FRONT) ||
                   (req_type == bole_pkg::REQ_INS_END));
      ram_waddr = (req_type == bole_pkg::REQ_INS_FRONT) ? head_dec : addr_sum;
      ram_wdata = item_value;
    end else begin
      ram_we    = (state == S_SHIFT) && wr_pend;
      ram_waddr = wr_addr;
      ram_wdata = rd_data;
    end
  end

  bole_ram #(
    .WIDTH (DATA_W),
    .DEPTH (bole_pkg::CAPACITY)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_sum),
    .rdata (rd_data)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      cmp_valid    <= 1'b0;
      wr_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // Default result fields for single-beat answers
            result_value    <= '0;
            result_position <= '0;
            last_of_run     <= 1'b1;
            list_length     <= POS_W'(count);
            val_reg         <= item_value;
            rd_idx          <= '0;
            cmp_valid       <= 1'b0;
            wr_pend         <= 1'b0;
            del_mode        <= (req_type == bole_pkg::REQ_DEL_VAL);
            unique case (req_type)
              bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_END: begin
                result_valid <= 1'b1;
                if (is_full) begin
                  status <= bole_pkg::ST_FULL;
                end else begin
                  status      <= bole_pkg::ST_OK;
                  count       <= count + CNT_W'(1);
                  list_length <= POS_W'(count + CNT_W'(1));
                  if (req_type == bole_pkg::REQ_INS_FRONT) begin
                    head <= head_dec;
                  end
                end
              end
              bole_pkg::REQ_SEARCH, bole_pkg::REQ_DEL_VAL: begin
                if (is_empty) begin
                  result_valid <= 1'b1;
                  status       <= bole_pkg::ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              bole_pkg::REQ_DEL_POS: begin
                if (is_empty) begin
                  result_valid <= 1'b1;
                  status       <= bole_pkg::ST_EMPTY;
                end else if (CNT_W'(item_position) >= count) begin
                  result_valid <= 1'b1;
                  status       <= bole_pkg::ST_BAD_POS;
                end else begin
                  rd_idx <= CNT_W'(item_position);
                  state  <= S_FETCH;
                end
              end
              bole_pkg::REQ_DUMP: begin
                if (is_empty) begin
                  result_valid <= 1'b1;
                  status       <= bole_pkg::ST_EMPTY;
                end else begin
                  state <= S_DUMP;
                end
              end
              default: begin
                // unused request code: drop it
              end
            endcase
          end
        end

        S_SCAN: begin
          cmp_valid <= ram_re;
          cmp_idx   <= rd_idx;
          if (ram_re) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (cmp_valid && (rd_data == val_reg)) begin
            if (del_mode) begin
              // hand over to the shift walk just past the match
              rm_value  <= rd_data;
              rd_idx    <= cmp_idx + CNT_W'(1);
              cmp_valid <= 1'b0;
              wr_pend   <= 1'b0;
              state     <= S_SHIFT;
            end else begin
              result_valid    <= 1'b1;
              status          <= bole_pkg::ST_OK;
              result_position <= POS_W'(cmp_idx + CNT_W'(1));
              cmp_valid       <= 1'b0;
              state           <= S_IDLE;
            end
          end else if (!cmp_valid && !ram_re) begin
            result_valid <= 1'b1;
            status       <= bole_pkg::ST_NOT_FOUND;
            state        <= S_IDLE;
          end
        end

        S_FETCH: begin
          rd_idx <= rd_idx + CNT_W'(1);
          state  <= S_TAKE;
        end

        S_TAKE: begin
          rm_value <= rd_data;
          wr_pend  <= 1'b0;
          state    <= S_SHIFT;
        end

        S_SHIFT: begin
          // read entry i, write it to place i-1 in the next cycle
          wr_pend <= ram_re;
          if (ram_re) begin
            rd_idx  <= rd_idx + CNT_W'(1);
            wr_addr <= sum_dec;
          end
          if (!ram_re && !wr_pend) begin
            count        <= count - CNT_W'(1);
            list_length  <= POS_W'(count - CNT_W'(1));
            result_valid <= 1'b1;
            status       <= bole_pkg::ST_OK;
            result_value <= rm_value;
            state        <= S_IDLE;
          end
        end

        S_DUMP: begin
          cmp_valid <= ram_re;
          cmp_idx   <= rd_idx;
          if (ram_re) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (cmp_valid) begin
            result_valid    <= 1'b1;
            status          <= bole_pkg::ST_OK;
            result_value    <= rd_data;
            result_position <= POS_W'(cmp_idx + CNT_W'(1));
            last_of_run     <= (cmp_idx + CNT_W'(1) == count);
            if (cmp_idx + CNT_W'(1) == count) begin
              cmp_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(bole_pkg::CAPACITY))
    else $error("entry count above capacity");

  // A result that is not the last of its run is followed by another beat
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_of_run) |=> result_valid)
    else $error("result run broken before its last beat");

  // Every result reports the length held by the engine
  a_length_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (list_length == POS_W'(count)))
    else $error("reported length differs from entry count");

  // The shift walk never reads and writes the same place in one cycle
  a_shift_no_clash: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && ram_we && ram_re) |-> (ram_waddr != addr_sum))
    else $error("shift write collides with read");

endmodule

// ===== tb/bounded_ordered_list_engine_test.sv =====
// Self-checking testbench for the bounded ordered list engine: directed and random requests.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_test;

  localparam int CAPACITY = bole_pkg::CAPACITY;
  localparam int REQ_W    = bole_pkg::REQ_W;
  localparam int DATA_W   = bole_pkg::DATA_W;
  localparam int POS_IN_W = bole_pkg::POS_IN_W;
  localparam int STAT_W   = bole_pkg::STAT_W;
  localparam int POS_W    = bole_pkg::POS_W;

  // Request codes that the engine takes and ignores
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Worst case is far below this: ~380 requests, each with its idle gap
  // and a walk of at most the full list.
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_REQUESTS = 356;

  typedef struct {
    logic [REQ_W-1:0]           kind;
    logic signed [DATA_W-1:0]   value;
    logic [POS_IN_W-1:0]        position;
  } list_request_t;

  typedef struct {
    logic [STAT_W-1:0]          status;
    logic signed [DATA_W-1:0]   value;
    logic [POS_W-1:0]           position;
    logic [POS_W-1:0]           length;
    logic                       last;
    longint                     stamp;
  } list_answer_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] req_type = '0;
  logic signed [DATA_W-1:0] item_value = '0;
  logic [POS_IN_W-1:0] item_position = '0;
  logic result_valid;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] result_value;
  logic [POS_W-1:0] result_position;
  logic [POS_W-1:0] list_length;
  logic last_of_run;

  list_request_t pending_requests[$];
  list_answer_t list_answers[$];
  logic signed [DATA_W-1:0] mirror_list[$];  // predicted list contents, front first

  list_request_t on_bus;
  list_answer_t head;
  int idle_left = 0;
  int stretch_left = 0;
  bit calm_stretch = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  bounded_ordered_list_engine dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .item_value      (item_value),
    .item_position   (item_position),
    .result_valid    (result_valid),
    .status          (status),
    .result_value    (result_value),
    .result_position (result_position),
    .list_length     (list_length),
    .last_of_run     (last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Record one predicted result beat; list length is taken after the change.
  task automatic note_answer(input logic [STAT_W-1:0] st, input logic signed [DATA_W-1:0] v,
                             input int pos, input logic last);
    list_answer_t a;
    a.status = st;
    a.value = v;
    a.position = POS_W'(pos);
    a.length = POS_W'(mirror_list.size());
    a.last = last;
    a.stamp = $time;
    list_answers.push_back(a);
  endtask

  // Apply one accepted request to the mirrored list and queue its result beats.
  task automatic apply_list_request(input list_request_t rq);
    logic signed [DATA_W-1:0] taken;
    int hit;
    int n;
    hit = -1;
    n = mirror_list.size();
    case (rq.kind)
      bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_END: begin
        if (n >= CAPACITY) begin
          note_answer(bole_pkg::ST_FULL, '0, 0, 1'b1);
        end else begin
          if (rq.kind == bole_pkg::REQ_INS_FRONT) mirror_list.push_front(rq.value);
          else mirror_list.push_back(rq.value);
          note_answer(bole_pkg::ST_OK, '0, 0, 1'b1);
        end
      end
      bole_pkg::REQ_SEARCH, bole_pkg::REQ_DEL_VAL: begin
        if (n == 0) begin
          note_answer(bole_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          // first match only
          for (int i = 0; i < n; i++) begin
            if (hit < 0 && mirror_list[i] == rq.value) hit = i;
          end
          if (hit < 0) begin
            note_answer(bole_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
          end else if (rq.kind == bole_pkg::REQ_SEARCH) begin
            note_answer(bole_pkg::ST_OK, '0, hit + 1, 1'b1);
          end else begin
            taken = mirror_list[hit];
            mirror_list.delete(hit);
            note_answer(bole_pkg::ST_OK, taken, 0, 1'b1);
          end
        end
      end
      bole_pkg::REQ_DEL_POS: begin
        if (n == 0) begin
          note_answer(bole_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else if (int'(rq.position) >= n) begin
          note_answer(bole_pkg::ST_BAD_POS, '0, 0, 1'b1);
        end else begin
          taken = mirror_list[rq.position];
          mirror_list.delete(rq.position);
          note_answer(bole_pkg::ST_OK, taken, 0, 1'b1);
        end
      end
      bole_pkg::REQ_DUMP: begin
        if (n == 0) begin
          note_answer(bole_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            note_answer(bole_pkg::ST_OK, mirror_list[i], i + 1, i == n - 1);
          end
        end
      end
      default: ;  // spare codes: no beat, no change
    endcase
  endtask

  task automatic queue_request(input logic [REQ_W-1:0] kind,
                               input logic signed [DATA_W-1:0] v, input int pos);
    list_request_t rq;
    rq.kind = kind;
    rq.value = v;
    rq.position = POS_IN_W'(pos);
    pending_requests.push_back(rq);
  endtask

  // Values mostly from a small pool so that searches and deletes hit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] pool[10];
    pool = '{32'sd0, 32'sd1, -32'sd1, VAL_MIN, VAL_MAX, 32'sd2, 32'sd3, 32'sd100,
             -32'sd100, 32'sh5555_5555};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 9)];
    return $urandom;
  endfunction

  function automatic list_request_t draw_request(input traffic_mix_t mix);
    list_request_t rq;
    int roll;
    int ins_pct;
    int srch_pct;
    int dval_pct;
    int dpos_pct;
    int dump_pct;
    case (mix)
      MIX_GROW: begin
        ins_pct = 80; srch_pct = 8;  dval_pct = 4;  dpos_pct = 3;  dump_pct = 4;
      end
      MIX_SHRINK: begin
        ins_pct = 15; srch_pct = 10; dval_pct = 35; dpos_pct = 30; dump_pct = 8;
      end
      default: begin
        ins_pct = 40; srch_pct = 20; dval_pct = 15; dpos_pct = 12; dump_pct = 11;
      end
    endcase
    roll = $urandom_range(0, 99);
    rq.value = pick_value();
    rq.position = POS_IN_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, 7));
    if (roll < ins_pct) begin
      rq.kind = $urandom_range(0, 1) ? bole_pkg::REQ_INS_FRONT : bole_pkg::REQ_INS_END;
    end else if (roll < ins_pct + srch_pct) begin
      rq.kind = bole_pkg::REQ_SEARCH;
    end else if (roll < ins_pct + srch_pct + dval_pct) begin
      rq.kind = bole_pkg::REQ_DEL_VAL;
    end else if (roll < ins_pct + srch_pct + dval_pct + dpos_pct) begin
      rq.kind = bole_pkg::REQ_DEL_POS;
    end else if (roll < ins_pct + srch_pct + dval_pct + dpos_pct + dump_pct) begin
      rq.kind = bole_pkg::REQ_DUMP;
    end else begin
      rq.kind = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
    end
    return rq;
  endfunction

  // Driver: hold a request beat until busy is low at an edge, then idle for a
  // drawn number of cycles before presenting the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_list_request(on_bus);
        // Alternate between stretches with no idling and stretches with gaps
        if (stretch_left == 0) begin
          calm_stretch = 1'($urandom_range(0, 1));
          stretch_left = $urandom_range(10, 30);
        end
        stretch_left--;
        idle_left = calm_stretch ? 0 : $urandom_range(0, 15);
      end
      // Keep the beat on the bus while the engine is busy
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          on_bus = pending_requests.pop_front();
          req_type <= on_bus.kind;
          item_value <= on_bus.value;
          item_position <= on_bus.position;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat must match the oldest prediction that was made
  // at an earlier edge.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (list_answers.size() == 0 || list_answers[0].stamp >= $time) begin
        $error("result beat with nothing expected: status %0d value %0d position %0d",
               status, result_value, result_position);
        mismatches++;
      end else begin
        head = list_answers.pop_front();
        if (status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, status);
          mismatches++;
        end
        if (result_value !== head.value) begin
          $error("result_value: expected %0d, got %0d", head.value, result_value);
          mismatches++;
        end
        if (result_position !== head.position) begin
          $error("result_position: expected %0d, got %0d", head.position, result_position);
          mismatches++;
        end
        if (list_length !== head.length) begin
          $error("list_length: expected %0d, got %0d", head.length, list_length);
          mismatches++;
        end
        if (last_of_run !== head.last) begin
          $error("last_of_run: expected %0d, got %0d", head.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    traffic_mix_t mix;
    int phase_left;

    // Directed: empty-list errors first, then extremes, search hits and misses,
    // bad positions, duplicates and spare codes, ending on an empty list.
    queue_request(bole_pkg::REQ_DUMP, '0, 0);
    queue_request(bole_pkg::REQ_SEARCH, '0, 0);
    queue_request(bole_pkg::REQ_DEL_VAL, '0, 0);
    queue_request(bole_pkg::REQ_DEL_POS, '0, 0);
    queue_request(bole_pkg::REQ_INS_END, VAL_MIN, 0);
    queue_request(bole_pkg::REQ_INS_FRONT, VAL_MAX, 0);
    queue_request(bole_pkg::REQ_INS_END, -32'sd1, 0);
    queue_request(bole_pkg::REQ_INS_FRONT, 32'sd0, 0);
    queue_request(bole_pkg::REQ_SEARCH, -32'sd1, 0);
    queue_request(bole_pkg::REQ_SEARCH, 32'sd0, 0);
    queue_request(bole_pkg::REQ_SEARCH, 32'sd12345, 0);
    queue_request(bole_pkg::REQ_DUMP, '0, 0);
    queue_request(bole_pkg::REQ_DEL_POS, '0, 4);        // one past the end
    queue_request(bole_pkg::REQ_DEL_POS, '0, 31);
    queue_request(bole_pkg::REQ_DEL_VAL, 32'sd99, 0);
    queue_request(bole_pkg::REQ_DEL_VAL, VAL_MIN, 0);
    queue_request(bole_pkg::REQ_DEL_POS, '0, 0);
    queue_request(REQ_SPARE_LO, 32'sd7, 3);
    queue_request(REQ_SPARE_HI, -32'sd1, 31);
    queue_request(bole_pkg::REQ_INS_END, VAL_MAX, 0);   // duplicate: delete takes the first
    queue_request(bole_pkg::REQ_DEL_VAL, VAL_MAX, 0);
    queue_request(bole_pkg::REQ_DEL_POS, '0, 1);        // last entry
    queue_request(bole_pkg::REQ_DUMP, '0, 0);
    queue_request(bole_pkg::REQ_DEL_POS, '0, 0);

    // Random: open with a growth phase to reach a full list, then mix phases.
    mix = MIX_GROW;
    phase_left = 45;
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: mix = MIX_GROW;
          1: mix = MIX_SHRINK;
          default: mix = MIX_BALANCED;
        endcase
        phase_left = $urandom_range(20, 50);
      end
      pending_requests.push_back(draw_request(mix));
      phase_left--;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats taken, all results seen, then a tail for strays.
    // Sample between edges so the clocked blocks have settled.
    @(negedge clk);
    while (pending_requests.size() != 0 || start) @(negedge clk);
    while (list_answers.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (list_answers.size() != 0) begin
      $error("result beats missing: %0d still expected", list_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
